[sv/ohp_pkg.sv]
// ============================================================================
// ohp_pkg: shared types and constants for the opponent hue projection block
// Holds the widths, the register indexes, the state encoding and the
// functions that turn a hue angle into signed blend weights per channel.
// ============================================================================
package ohp_pkg;

    localparam int PIXEL_BITS = 8;
    localparam int IN_W       = 8;
    localparam int HUE_W      = 9;
    localparam int CFG_W      = 17;
    localparam int THR_W      = 17;
    localparam int COEF_W     = 8;
    localparam int TERM_W     = COEF_W + 2;
    localparam int V_W        = PIXEL_BITS + 8;
    localparam int P_W        = PIXEL_BITS + 7;
    localparam int D_W        = P_W + 1;
    localparam int R_W        = D_W + 1;
    localparam int Q_W        = 17;
    localparam int CNT_W      = 5;
    localparam int PROJ_W     = 16;
    localparam int CMP_W      = V_W + 16;
    localparam int FULL_SCALE = 120 * ((1 << PIXEL_BITS) - 1);
    localparam int THR_RESET  = 32768;

    typedef enum logic [0:0] {
        REG_HUE    = 1'b0,
        REG_THRESH = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROJ,
        ST_LOAD,
        ST_DIV,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic signed [COEF_W-1:0] cr;
        logic signed [COEF_W-1:0] cg;
        logic signed [COEF_W-1:0] cb;
    } t_coefs;

    function automatic t_coefs hue_blend(input logic [HUE_W-1:0] s);
        t_coefs w;
        w = '0;
        if (s <= 9'd120) begin
            w.cr = COEF_W'(9'd120 - s);
            w.cg = COEF_W'(s);
        end else if (s <= 9'd240) begin
            w.cg = COEF_W'(9'd240 - s);
            w.cb = COEF_W'(s - 9'd120);
        end else begin
            w.cb = COEF_W'(9'd360 - s);
            w.cr = COEF_W'(s - 9'd240);
        end
        return w;
    endfunction

    function automatic t_coefs hue_coefs(input logic [HUE_W-1:0] hue);
        logic [HUE_W-1:0] a;
        logic [HUE_W-1:0] opp;
        t_coefs w;
        t_coefs o;
        t_coefs c;
        a   = (hue > 9'd360) ? 9'd360 : hue;
        opp = (a < 9'd181) ? a + 9'd180 : a - 9'd180;
        w   = hue_blend(a);
        o   = hue_blend(opp);
        c.cr = w.cr - o.cr;
        c.cg = w.cg - o.cg;
        c.cb = w.cb - o.cb;
        return c;
    endfunction

endpackage

[sv/opponent_hue_projection.sv]
// A word is accepted only in the idle state; the input stalls until the result word
// is loaded into the output register, also while a stalled output holds it back.
// The projection runs bit-serially over the pixel bits, one state loads the
// divider, the radix-2 divider forms the quotient and the idle state takes the next word.
// Synchronous active-low reset sets hue 0, threshold 32768 and clears the
// frame maximum; no clearing pass is needed.
// ============================================================================
// opponent_hue_projection: bit-serial hue projection with frame presence flag
// Projects each pixel onto a hue direction, divides it into a Q1.16 fraction
// of the span from minus to plus the corner peak and flags on frame end whether
// the frame maximum's fraction exceeds the threshold.
// ============================================================================
module opponent_hue_projection (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [ohp_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [ohp_pkg::IN_W-1:0]   i_red,
    input  logic [ohp_pkg::IN_W-1:0]   i_green,
    input  logic [ohp_pkg::IN_W-1:0]   i_blue,
    input  logic                       i_frame_end,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [ohp_pkg::PROJ_W-1:0] o_projection,
    output logic [ohp_pkg::Q_W-1:0]    o_fraction,
    output logic                       o_present,
    output logic                       o_last
);
    import ohp_pkg::*;

    t_state                    r_state;
    t_state                    n_state;
    t_coefs                    r_coef;
    logic [THR_W-1:0]          r_thresh;
    logic [P_W-1:0]            r_peak;
    logic [PIXEL_BITS-1:0]     r_red;
    logic [PIXEL_BITS-1:0]     r_green;
    logic [PIXEL_BITS-1:0]     r_blue;
    logic                      r_last;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [V_W-1:0]     r_acc;
    logic signed [V_W-1:0]     r_frame_peak;
    logic signed [V_W-1:0]     r_end_peak;
    logic signed [V_W:0]       r_s;
    logic [CMP_W-1:0]          r_prod;
    logic                      r_pres;
    logic [R_W-1:0]            r_rem;
    logic [Q_W-1:0]            r_quo;
    logic                      r_o_valid;
    logic signed [PROJ_W-1:0]  r_o_proj;
    logic [Q_W-1:0]            r_o_frac;
    logic                      r_o_present;
    logic                      r_o_last;

    logic                      accept;
    logic                      out_free;
    logic                      out_load;
    logic signed [TERM_W-1:0]  term;
    logic [8:0]                pos_sum;
    logic [P_W+1:0]            peak_full;
    logic signed [V_W:0]       peak_ext;
    logic signed [V_W:0]       v_plus;
    logic signed [V_W-1:0]     peak_new;
    logic [D_W-1:0]            divisor;
    logic                      rem_ge;
    logic [R_W-1:0]            rem_sub;
    logic [THR_W-1:0]          thr_inc;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;

    always_comb begin
        o_stall  = (r_state != ST_IDLE);
        out_load = 1'b0;
        unique case (r_state)
            ST_DIV:  out_load = (r_cnt == '0) && out_free;
            ST_HOLD: out_load = out_free;
            default: out_load = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = ST_PROJ;
            ST_PROJ: if (r_cnt == '0) n_state = ST_LOAD;
            ST_LOAD: n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == '0) n_state = out_free ? ST_IDLE : ST_HOLD;
            end
            ST_HOLD: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        term = (r_red[PIXEL_BITS-1]   ? TERM_W'(r_coef.cr) : TERM_W'(0))
             + (r_green[PIXEL_BITS-1] ? TERM_W'(r_coef.cg) : TERM_W'(0))
             + (r_blue[PIXEL_BITS-1]  ? TERM_W'(r_coef.cb) : TERM_W'(0));
        pos_sum = (r_coef.cr[COEF_W-1] ? 9'd0 : 9'(r_coef.cr))
                + (r_coef.cg[COEF_W-1] ? 9'd0 : 9'(r_coef.cg))
                + (r_coef.cb[COEF_W-1] ? 9'd0 : 9'(r_coef.cb));
        peak_full = ((P_W+2)'(pos_sum) << PIXEL_BITS) - (P_W+2)'(pos_sum);
        peak_ext  = (V_W+1)'($signed({1'b0, r_peak}));
        v_plus    = (V_W+1)'(r_acc) + peak_ext;
        peak_new  = (r_acc > r_frame_peak) ? r_acc : r_frame_peak;
        divisor   = {r_peak, 1'b0};
        rem_ge    = (r_rem >= R_W'(divisor));
        rem_sub   = rem_ge ? (r_rem - R_W'(divisor)) : r_rem;
        thr_inc   = r_thresh + THR_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_coef       <= hue_coefs('0);
            r_thresh     <= THR_W'(THR_RESET);
            r_peak       <= P_W'(FULL_SCALE);
            r_frame_peak <= V_W'(-FULL_SCALE);
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_peak  <= P_W'(peak_full);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_HUE:    r_coef   <= hue_coefs(i_cfg_data[HUE_W-1:0]);
                    REG_THRESH: r_thresh <= i_cfg_data[THR_W-1:0];
                    default:    r_thresh <= r_thresh;
                endcase
            end
            if (r_state == ST_LOAD) begin
                r_frame_peak <= i_rst_n && r_last ? V_W'(-FULL_SCALE) : peak_new;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s    <= (V_W+1)'(r_end_peak) + peak_ext;
        r_prod <= CMP_W'(thr_inc) * CMP_W'(r_peak);
        r_pres <= !r_s[V_W] && !r_thresh[THR_W-1] && (CMP_W'({r_s, 15'd0}) >= r_prod);
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_red   <= PIXEL_BITS'(i_red);
                    r_green <= PIXEL_BITS'(i_green);
                    r_blue  <= PIXEL_BITS'(i_blue);
                    r_last  <= i_frame_end;
                    r_acc   <= '0;
                    r_cnt   <= CNT_W'(PIXEL_BITS - 1);
                end
            end
            ST_PROJ: begin
                r_acc   <= (r_acc <<< 1) + V_W'(term);
                r_red   <= r_red << 1;
                r_green <= r_green << 1;
                r_blue  <= r_blue << 1;
                r_cnt   <= r_cnt - CNT_W'(1);
            end
            ST_LOAD: begin
                r_rem <= R_W'(unsigned'(v_plus));
                r_cnt <= CNT_W'(Q_W - 1);
                if (r_last) begin
                    r_end_peak <= peak_new;
                end
            end
            ST_DIV: begin
                r_quo <= {r_quo[Q_W-2:0], rem_ge};
                r_rem <= rem_sub << 1;
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
            default: r_cnt <= r_cnt;
        endcase
        if (out_load) begin
            r_o_proj    <= PROJ_W'(r_acc);
            r_o_frac    <= (r_state == ST_DIV) ? {r_quo[Q_W-2:0], rem_ge} : r_quo;
            r_o_present <= r_last && r_pres;
            r_o_last    <= r_last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_projection = r_o_proj;
    assign o_fraction   = r_o_frac;
    assign o_present    = r_o_present;
    assign o_last       = r_o_last;

    a_valid_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == ST_DIV || $past(r_state) == ST_HOLD))
        else $error("result word raised without a finished division");

    a_fraction_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fraction <= Q_W'(65536)))
        else $error("fraction above one");

    a_present_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> !o_present)
        else $error("presence flagged on a word that does not end a frame");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && $past(r_state) == ST_DIV)
            |-> (r_rem < (R_W'(divisor) << 1)))
        else $error("divider remainder out of range");

endmodule
